@@ hw/rtl/fjsop_pkg.sv @@
// ----------------------------------------------------------------------------
// fjsop_pkg
// Shared types and constants of the flat JSON string object parser: item and
// result beats, the parser phases, result kinds and the run that one input
// byte leaves in the queue between the front and back ends.
// ----------------------------------------------------------------------------
package fjsop_pkg;

    // Most results that a single input byte can cause.
    localparam int RUN_MAX = 5;
    localparam int RUN_IW  = $clog2(RUN_MAX);
    localparam int RUN_CW  = $clog2(RUN_MAX + 1);

    // Depth of the run queue between front and back ends.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Code point width covers a combined surrogate pair.
    localparam int CP_W = 21;

    // 0x10000 - 0xDC00: folds both offsets of the surrogate combination.
    localparam logic [CP_W-1:0] SURR_OFFSET = 21'h002400;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_U     = 8'h75;

    typedef enum logic [3:0] {
        PH_OPEN    = 4'd0,
        PH_FIRST   = 4'd1,
        PH_KEY     = 4'd2,
        PH_STR     = 4'd3,
        PH_ESC     = 4'd4,
        PH_HEX_HI  = 4'd5,
        PH_SURR_BS = 4'd6,
        PH_SURR_U  = 4'd7,
        PH_HEX_LO  = 4'd8,
        PH_COLON   = 4'd9,
        PH_VALUE   = 4'd10,
        PH_SEP     = 4'd11,
        PH_DONE    = 4'd12
    } t_phase;

    typedef enum logic [2:0] {
        KIND_KEY      = 3'd0,
        KIND_VAL      = 3'd1,
        KIND_KEY_END  = 3'd2,
        KIND_PAIR_END = 3'd3,
        KIND_ACCEPT   = 3'd4,
        KIND_ERROR    = 3'd5
    } t_kind;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       last_of_run;
    } t_result;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
    } t_slot;

    typedef struct packed {
        logic [RUN_CW-1:0]          count;
        t_slot [RUN_MAX-1:0]        slots;
    } t_run;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [2:0]       count;
        logic [3:0][7:0]  bytes;
    } t_utf8;

endpackage

@@ hw/rtl/fjsop_front.sv @@
// ----------------------------------------------------------------------------
// fjsop_front
// Parser front end: runs the phase machine on each accepted byte, decodes
// escapes and UTF-8 encodes code points, and hands the run of results that
// the byte causes to the queue as one entry.
// ----------------------------------------------------------------------------
module fjsop_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  fjsop_pkg::t_item  i_item,
    output logic              o_push,
    output fjsop_pkg::t_run   o_run
);

    fjsop_pkg::t_phase r_phase, n_phase, proc_phase;
    logic [15:0] r_hex_acc, n_hex_acc;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_pending, n_pending;
    logic        r_in_value, n_in_value;

    logic [7:0]  c;
    logic        is_ws;
    logic        hok;
    logic [3:0]  hnib;
    logic [15:0] acc_new;
    logic        hex_last;
    logic        surr_hi;
    logic        esc_ok;
    logic        esc_u;
    logic [7:0]  esc_byte;
    fjsop_pkg::t_phase str_phase;
    fjsop_pkg::t_kind  dkind;

    logic                         enc_en;
    logic [fjsop_pkg::CP_W-1:0]   enc_cp;
    fjsop_pkg::t_utf8             enc;
    logic                         one_en;
    fjsop_pkg::t_slot             one_slot;
    logic [fjsop_pkg::RUN_CW-1:0] cnt;
    fjsop_pkg::t_run              run;

    assign c = i_item.text_byte;

    // Byte classification shared by the next-state and result logic.
    always_comb begin
        is_ws = c inside {fjsop_pkg::CH_SPACE, fjsop_pkg::CH_TAB,
                          fjsop_pkg::CH_LF, fjsop_pkg::CH_CR};
        hok  = 1'b1;
        hnib = c[3:0];
        if (c inside {[8'h30:8'h39]}) begin
            hnib = c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hnib = c[3:0] + 4'd9;
        end else begin
            hok = 1'b0;
        end
        acc_new  = {r_hex_acc[11:0], hnib};
        hex_last = hok && (&r_hex_cnt);
        surr_hi  = acc_new inside {[16'hD800:16'hDBFF]};

        esc_ok   = 1'b1;
        esc_u    = (c == fjsop_pkg::CH_LOW_U);
        esc_byte = c;
        case (c)
            fjsop_pkg::CH_QUOTE,
            fjsop_pkg::CH_BSLASH,
            fjsop_pkg::CH_SLASH:  esc_byte = c;
            fjsop_pkg::CH_LOW_B:  esc_byte = fjsop_pkg::CH_BACKSPACE;
            fjsop_pkg::CH_LOW_F:  esc_byte = fjsop_pkg::CH_FORMFEED;
            fjsop_pkg::CH_LOW_N:  esc_byte = fjsop_pkg::CH_LF;
            fjsop_pkg::CH_LOW_R:  esc_byte = fjsop_pkg::CH_CR;
            fjsop_pkg::CH_LOW_T:  esc_byte = fjsop_pkg::CH_TAB;
            default:              esc_ok   = 1'b0;
        endcase

        if (c == fjsop_pkg::CH_QUOTE) begin
            str_phase = r_in_value ? fjsop_pkg::PH_SEP : fjsop_pkg::PH_COLON;
        end else if (c == fjsop_pkg::CH_BSLASH) begin
            str_phase = fjsop_pkg::PH_ESC;
        end else begin
            str_phase = fjsop_pkg::PH_STR;
        end
        dkind = r_in_value ? fjsop_pkg::KIND_VAL : fjsop_pkg::KIND_KEY;
    end

    // Next state.
    always_comb begin
        n_hex_acc  = r_hex_acc;
        n_hex_cnt  = r_hex_cnt;
        n_pending  = r_pending;
        n_in_value = r_in_value;
        proc_phase = r_phase;
        case (r_phase)
            fjsop_pkg::PH_OPEN: begin
                if (c == fjsop_pkg::CH_LBRACE) proc_phase = fjsop_pkg::PH_FIRST;
                else if (!is_ws)               proc_phase = fjsop_pkg::PH_DONE;
            end
            fjsop_pkg::PH_FIRST: begin
                if (c == fjsop_pkg::CH_RBRACE) begin
                    proc_phase = fjsop_pkg::PH_DONE;
                end else if (c == fjsop_pkg::CH_QUOTE) begin
                    proc_phase = fjsop_pkg::PH_STR;
                    n_in_value = 1'b0;
                end else if (!is_ws) begin
                    proc_phase = fjsop_pkg::PH_DONE;
                end
            end
            fjsop_pkg::PH_KEY: begin
                if (c == fjsop_pkg::CH_QUOTE) begin
                    proc_phase = fjsop_pkg::PH_STR;
                    n_in_value = 1'b0;
                end else if (!is_ws) begin
                    proc_phase = fjsop_pkg::PH_DONE;
                end
            end
            fjsop_pkg::PH_STR: begin
                proc_phase = str_phase;
            end
            fjsop_pkg::PH_ESC: begin
                if (esc_u) begin
                    proc_phase = fjsop_pkg::PH_HEX_HI;
                    n_hex_acc  = '0;
                    n_hex_cnt  = '0;
                end else begin
                    proc_phase = esc_ok ? fjsop_pkg::PH_STR : fjsop_pkg::PH_DONE;
                end
            end
            fjsop_pkg::PH_HEX_HI: begin
                if (!hok) begin
                    proc_phase = fjsop_pkg::PH_DONE;
                end else begin
                    n_hex_acc = acc_new;
                    if (hex_last) begin
                        n_hex_cnt = '0;
                        if (surr_hi) begin
                            n_pending  = acc_new;
                            proc_phase = fjsop_pkg::PH_SURR_BS;
                        end else begin
                            proc_phase = fjsop_pkg::PH_STR;
                        end
                    end else begin
                        n_hex_cnt = r_hex_cnt + 2'd1;
                    end
                end
            end
            fjsop_pkg::PH_SURR_BS: begin
                proc_phase = (c == fjsop_pkg::CH_BSLASH) ? fjsop_pkg::PH_SURR_U
                                                         : str_phase;
            end
            fjsop_pkg::PH_SURR_U: begin
                if (esc_u) begin
                    proc_phase = fjsop_pkg::PH_HEX_LO;
                    n_hex_acc  = '0;
                    n_hex_cnt  = '0;
                end else begin
                    proc_phase = esc_ok ? fjsop_pkg::PH_STR : fjsop_pkg::PH_DONE;
                end
            end
            fjsop_pkg::PH_HEX_LO: begin
                if (!hok) begin
                    proc_phase = fjsop_pkg::PH_DONE;
                end else begin
                    n_hex_acc = acc_new;
                    if (hex_last) begin
                        n_hex_cnt  = '0;
                        proc_phase = fjsop_pkg::PH_STR;
                    end else begin
                        n_hex_cnt = r_hex_cnt + 2'd1;
                    end
                end
            end
            fjsop_pkg::PH_COLON: begin
                if (c == fjsop_pkg::CH_COLON) proc_phase = fjsop_pkg::PH_VALUE;
                else if (!is_ws)              proc_phase = fjsop_pkg::PH_DONE;
            end
            fjsop_pkg::PH_VALUE: begin
                if (c == fjsop_pkg::CH_QUOTE) begin
                    proc_phase = fjsop_pkg::PH_STR;
                    n_in_value = 1'b1;
                end else if (!is_ws) begin
                    proc_phase = fjsop_pkg::PH_DONE;
                end
            end
            fjsop_pkg::PH_SEP: begin
                if (c == fjsop_pkg::CH_COMMA) proc_phase = fjsop_pkg::PH_KEY;
                else if (!is_ws)              proc_phase = fjsop_pkg::PH_DONE;
            end
            default: begin
                proc_phase = fjsop_pkg::PH_DONE;
            end
        endcase

        n_phase = proc_phase;
        if (i_item.end_of_text) begin
            n_phase    = fjsop_pkg::PH_OPEN;
            n_hex_acc  = '0;
            n_hex_cnt  = '0;
            n_pending  = '0;
            n_in_value = 1'b0;
        end
    end

    // Results: an optional UTF-8 sequence, then one single result, then the
    // early-end error.
    always_comb begin
        enc_en   = 1'b0;
        enc_cp   = {5'd0, r_pending};
        one_en   = 1'b0;
        one_slot = '{out_byte: c, kind: dkind};
        case (r_phase)
            fjsop_pkg::PH_OPEN: begin
                if (c != fjsop_pkg::CH_LBRACE && !is_ws) begin
                    one_en   = 1'b1;
                    one_slot = '{out_byte: 8'd0, kind: fjsop_pkg::KIND_ERROR};
                end
            end
            fjsop_pkg::PH_FIRST, fjsop_pkg::PH_SEP: begin
                if (c == fjsop_pkg::CH_RBRACE) begin
                    one_en   = 1'b1;
                    one_slot = '{out_byte: 8'd0, kind: fjsop_pkg::KIND_ACCEPT};
                end else if (!is_ws && !(r_phase == fjsop_pkg::PH_FIRST &&
                                         c == fjsop_pkg::CH_QUOTE) &&
                             !(r_phase == fjsop_pkg::PH_SEP &&
                               c == fjsop_pkg::CH_COMMA)) begin
                    one_en   = 1'b1;
                    one_slot = '{out_byte: 8'd0, kind: fjsop_pkg::KIND_ERROR};
                end
            end
            fjsop_pkg::PH_KEY, fjsop_pkg::PH_VALUE: begin
                if (c != fjsop_pkg::CH_QUOTE && !is_ws) begin
                    one_en   = 1'b1;
                    one_slot = '{out_byte: 8'd0, kind: fjsop_pkg::KIND_ERROR};
                end
            end
            fjsop_pkg::PH_COLON: begin
                if (c != fjsop_pkg::CH_COLON && !is_ws) begin
                    one_en   = 1'b1;
                    one_slot = '{out_byte: 8'd0, kind: fjsop_pkg::KIND_ERROR};
                end
            end
            fjsop_pkg::PH_STR, fjsop_pkg::PH_SURR_BS: begin
                // A lone high surrogate is flushed before the byte itself.
                if (r_phase == fjsop_pkg::PH_SURR_BS) begin
                    enc_en = (c != fjsop_pkg::CH_BSLASH);
                end
                if (r_phase == fjsop_pkg::PH_STR || c != fjsop_pkg::CH_BSLASH) begin
                    if (c == fjsop_pkg::CH_QUOTE) begin
                        one_en   = 1'b1;
                        one_slot = '{out_byte: 8'd0,
                                     kind: r_in_value ? fjsop_pkg::KIND_PAIR_END
                                                      : fjsop_pkg::KIND_KEY_END};
                    end else if (c != fjsop_pkg::CH_BSLASH) begin
                        one_en = 1'b1;
                    end
                end
            end
            fjsop_pkg::PH_ESC, fjsop_pkg::PH_SURR_U: begin
                if (r_phase == fjsop_pkg::PH_SURR_U) begin
                    enc_en = !esc_u;
                end
                if (!esc_u) begin
                    one_en = 1'b1;
                    if (esc_ok) begin
                        one_slot = '{out_byte: esc_byte, kind: dkind};
                    end else begin
                        one_slot = '{out_byte: 8'd0, kind: fjsop_pkg::KIND_ERROR};
                    end
                end
            end
            fjsop_pkg::PH_HEX_HI: begin
                if (!hok) begin
                    one_en   = 1'b1;
                    one_slot = '{out_byte: 8'd0, kind: fjsop_pkg::KIND_ERROR};
                end else if (hex_last && !surr_hi) begin
                    enc_en = 1'b1;
                    enc_cp = {5'd0, acc_new};
                end
            end
            fjsop_pkg::PH_HEX_LO: begin
                if (!hok) begin
                    one_en   = 1'b1;
                    one_slot = '{out_byte: 8'd0, kind: fjsop_pkg::KIND_ERROR};
                end else if (hex_last) begin
                    // The high half is known to lie in D800..DBFF, so its low
                    // ten bits are the offset and the sum cannot wrap.
                    enc_en = 1'b1;
                    enc_cp = {1'b0, r_pending[9:0], 10'd0} + {5'd0, acc_new}
                           + fjsop_pkg::SURR_OFFSET;
                end
            end
            default: begin
                one_en = 1'b0;
            end
        endcase

        enc.bytes = '0;
        if (enc_cp <= 21'h00007F) begin
            enc.count    = 3'd1;
            enc.bytes[0] = enc_cp[7:0];
        end else if (enc_cp <= 21'h0007FF) begin
            enc.count    = 3'd2;
            enc.bytes[0] = 8'hC0 | {3'd0, enc_cp[10:6]};
            enc.bytes[1] = 8'h80 | {2'd0, enc_cp[5:0]};
        end else if (enc_cp <= 21'h00FFFF) begin
            enc.count    = 3'd3;
            enc.bytes[0] = 8'hE0 | {4'd0, enc_cp[15:12]};
            enc.bytes[1] = 8'h80 | {2'd0, enc_cp[11:6]};
            enc.bytes[2] = 8'h80 | {2'd0, enc_cp[5:0]};
        end else begin
            enc.count    = 3'd4;
            enc.bytes[0] = 8'hF0 | {5'd0, enc_cp[20:18]};
            enc.bytes[1] = 8'h80 | {2'd0, enc_cp[17:12]};
            enc.bytes[2] = 8'h80 | {2'd0, enc_cp[11:6]};
            enc.bytes[3] = 8'h80 | {2'd0, enc_cp[5:0]};
        end

        run = '0;
        cnt = '0;
        if (enc_en) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < enc.count) begin
                    run.slots[cnt[fjsop_pkg::RUN_IW-1:0]] =
                        '{out_byte: enc.bytes[i], kind: dkind};
                    cnt = cnt + 1'b1;
                end
            end
        end
        if (one_en) begin
            run.slots[cnt[fjsop_pkg::RUN_IW-1:0]] = one_slot;
            cnt = cnt + 1'b1;
        end
        if (i_item.end_of_text && proc_phase != fjsop_pkg::PH_DONE) begin
            run.slots[cnt[fjsop_pkg::RUN_IW-1:0]] =
                '{out_byte: 8'd0, kind: fjsop_pkg::KIND_ERROR};
            cnt = cnt + 1'b1;
        end
        run.count = cnt;
    end

    assign o_run  = run;
    assign o_push = i_fire && (cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= fjsop_pkg::PH_OPEN;
            r_hex_acc  <= '0;
            r_hex_cnt  <= '0;
            r_pending  <= '0;
            r_in_value <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_hex_acc  <= n_hex_acc;
            r_hex_cnt  <= n_hex_cnt;
            r_pending  <= n_pending;
            r_in_value <= n_in_value;
        end
    end

`ifndef SYNTHESIS
    // Once the status is out, no later byte causes a new result.
    a_silent_after_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_phase == fjsop_pkg::PH_DONE) |-> !o_push)
        else $error("result pushed after the status");

    // A pending surrogate is always a high half.
    a_pending_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fjsop_pkg::PH_SURR_BS || r_phase == fjsop_pkg::PH_SURR_U ||
         r_phase == fjsop_pkg::PH_HEX_LO) |-> (r_pending[15:10] == 6'b110110))
        else $error("pending surrogate is not a high half");
`endif

endmodule

@@ hw/rtl/fjsop_fifo.sv @@
// ----------------------------------------------------------------------------
// fjsop_fifo
// Short queue of result runs between the parser front end and the result
// serializer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module fjsop_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  fjsop_pkg::t_run       i_run,
    input  logic                  i_pop,
    output fjsop_pkg::t_run       o_head,
    output fjsop_pkg::t_q_status  o_status
);

    fjsop_pkg::t_run r_mem [fjsop_pkg::Q_DEPTH];
    logic [fjsop_pkg::Q_AW-1:0] r_wr, r_rd;
    logic [fjsop_pkg::Q_CW-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_status.full  = (r_cnt == fjsop_pkg::Q_CW'(fjsop_pkg::Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == fjsop_pkg::Q_AW'(fjsop_pkg::Q_DEPTH - 1)) ? '0
                                                                          : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == fjsop_pkg::Q_AW'(fjsop_pkg::Q_DEPTH - 1)) ? '0
                                                                          : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + {{(fjsop_pkg::Q_CW-1){1'b0}}, do_push}
                           - {{(fjsop_pkg::Q_CW-1){1'b0}}, do_pop};
        end
    end

`ifndef SYNTHESIS
    // The front end only fires while there is room, so no run is ever dropped.
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("run pushed into a full queue");
`endif

endmodule

@@ hw/rtl/fjsop_back.sv @@
// ----------------------------------------------------------------------------
// fjsop_back
// Result serializer: walks the head run one result per cycle into the output
// register while it is free or popped, and marks the last result of each run.
// ----------------------------------------------------------------------------
module fjsop_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fjsop_pkg::t_run       i_head,
    input  fjsop_pkg::t_q_status  i_q,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output fjsop_pkg::t_result    o_result
);

    logic [fjsop_pkg::RUN_IW-1:0] r_idx;
    logic [fjsop_pkg::RUN_IW-1:0] last_idx;
    logic                         r_ovalid;
    fjsop_pkg::t_result           r_out;
    logic                         out_free;
    logic                         take;
    logic                         at_last;

    assign out_free = !r_ovalid || i_pop;
    assign take     = out_free && !i_q.empty;
    assign last_idx = fjsop_pkg::RUN_IW'(i_head.count - 1'b1);
    assign at_last  = (r_idx == last_idx);
    assign o_q_pop  = take && at_last;
    assign o_empty  = !r_ovalid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (take) begin
                r_ovalid <= 1'b1;
                r_idx    <= at_last ? '0 : r_idx + 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= '{out_byte:    i_head.slots[r_idx].out_byte,
                       kind:        i_head.slots[r_idx].kind,
                       last_of_run: at_last};
        end
    end

`ifndef SYNTHESIS
    // Every queued run holds one to five results.
    a_run_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q.empty |-> (i_head.count != '0 &&
                        i_head.count <= fjsop_pkg::RUN_CW'(fjsop_pkg::RUN_MAX)))
        else $error("queued run has a bad size");

    // The walk never runs past the end of the current run.
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q.empty |-> ({1'b0, r_idx} < {1'b0, i_head.count}))
        else $error("result index beyond run");
`endif

endmodule

@@ hw/rtl/flat_json_string_object_parser.sv @@
// The parser takes one input byte per cycle while the run queue is not full.
// The serializer sends one result per cycle into the output register while it is
// free or popped, so a byte that causes k results holds the output side for all k.
// A four-entry run queue lets the parser keep taking bytes during such bursts.
// Reset (synchronous, active low) returns the parser to expecting an opening
// brace and empties the queue and the output register.
// ----------------------------------------------------------------------------
// flat_json_string_object_parser
// Streaming parser of a flat JSON object of string keys and values, one text
// byte per beat in, one decoded byte or marker per beat out.
// ----------------------------------------------------------------------------
module flat_json_string_object_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fjsop_pkg::t_item    i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output fjsop_pkg::t_result  o_result
);

    logic                  fire;
    logic                  q_push;
    logic                  q_pop;
    fjsop_pkg::t_run       q_in;
    fjsop_pkg::t_run       q_head;
    fjsop_pkg::t_q_status  q_status;

    assign o_full = q_status.full;
    assign fire   = i_push && !q_status.full;

    fjsop_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (i_item),
        .o_push  (q_push),
        .o_run   (q_in)
    );

    fjsop_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_run    (q_in),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    fjsop_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (q_head),
        .i_q      (q_status),
        .o_q_pop  (q_pop),
        .i_pop    (i_pop),
        .o_empty  (o_empty),
        .o_result (o_result)
    );

endmodule
